>>> src/twsrm_pkg.sv
// ----------------------------------------------------------------------------
// Two-wire sensor register master package
// Shared types, register indexes and reset values for the serial master.
// ----------------------------------------------------------------------------
package twsrm_pkg;

   localparam int unsigned CSR_WIDTH       = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_TICKS       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURNAROUND_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESYNC_HOLD_TICKS = 2'd2;

   localparam logic [CSR_WIDTH-1:0] PHASE_TICKS_RESET       = 16'd2;
   localparam logic [CSR_WIDTH-1:0] TURNAROUND_TICKS_RESET  = 16'd5;
   localparam logic [CSR_WIDTH-1:0] RESYNC_HOLD_TICKS_RESET = 16'd100;

   // Request action codes.
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_RESYNC = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LOW     = 3'd1,
      PH_HIGH    = 3'd2,
      PH_TURN    = 3'd3,
      PH_RS_PRE  = 3'd4,
      PH_RS_LOW  = 3'd5,
      PH_RS_POST = 3'd6
   } phase_type;

   typedef struct packed {
      logic [CSR_WIDTH-1:0] phase_ticks;
      logic [CSR_WIDTH-1:0] turnaround_ticks;
      logic [CSR_WIDTH-1:0] resync_hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic       clock_line;
      logic       data_line_out;
      logic       data_drive_enable;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
   } result_type;

endpackage

>>> src/twsrm_if.sv
// ----------------------------------------------------------------------------
// Two-wire sensor register master channels
// Valid/ready request and response channels of the serial master.
// ----------------------------------------------------------------------------
interface twsrm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [6:0] reg_address;
   logic [7:0] write_byte;
   logic       data_line_in;

   modport source (output valid, action, reg_address, write_byte, data_line_in,
                   input ready);
   modport sink (input valid, action, reg_address, write_byte, data_line_in,
                 output ready);
endinterface

interface twsrm_rsp_if;
   logic       valid;
   logic       ready;
   logic       clock_line;
   logic       data_line_out;
   logic       data_drive_enable;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;

   modport source (output valid, clock_line, data_line_out, data_drive_enable,
                   busy_res, done_res, read_byte, input ready);
   modport sink (input valid, clock_line, data_line_out, data_drive_enable,
                 busy_res, done_res, read_byte, output ready);
endinterface

>>> src/two_wire_sensor_register_master_top.sv
// ----------------------------------------------------------------------------
// Two-wire sensor register master
// Pin-level master for a clock plus bidirectional data serial link, one
// timing tick per request.
//
//   channel   direction  handshake          contents
//   req_ch    in         valid/ready        action, address, write byte, pin
//   rsp_ch    out        valid/ready        pin levels, busy, done, read byte
//   csr_*     in         write enable only  phase, turnaround, resync hold
//
// Every request is one tick and gives one response; a request is taken in
// every cycle while the response register is empty or being drained.
// The path from request to response register runs through the combinational
// phase sequencer; the response register decouples the two sides.
// Reset is synchronous: the link goes idle with the clock line high and the
// registers return to 2, 5 and 100 ticks.
// A stalled response holds the request side until it is taken.
// ----------------------------------------------------------------------------
module two_wire_sensor_register_master_top (
   input  logic                                  clock,
   input  logic                                  reset,
   twsrm_req_if.sink                             req_ch,
   twsrm_rsp_if.source                           rsp_ch,
   input  logic                                  csr_write_enable,
   input  logic [twsrm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [twsrm_pkg::CSR_WIDTH-1:0]       csr_write_data
);

   twsrm_pkg::cfg_type    cfg_ff;
   twsrm_pkg::result_type result;
   twsrm_pkg::result_type rsp_data_ff;
   logic                  rsp_valid_ff;
   logic                  req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks       <= twsrm_pkg::PHASE_TICKS_RESET;
         cfg_ff.turnaround_ticks  <= twsrm_pkg::TURNAROUND_TICKS_RESET;
         cfg_ff.resync_hold_ticks <= twsrm_pkg::RESYNC_HOLD_TICKS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            twsrm_pkg::CSR_PHASE_TICKS:       cfg_ff.phase_ticks       <= csr_write_data;
            twsrm_pkg::CSR_TURNAROUND_TICKS:  cfg_ff.turnaround_ticks  <= csr_write_data;
            twsrm_pkg::CSR_RESYNC_HOLD_TICKS: cfg_ff.resync_hold_ticks <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   twsrm_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_accept),
      .action       (req_ch.action),
      .reg_address  (req_ch.reg_address),
      .write_byte   (req_ch.write_byte),
      .data_line_in (req_ch.data_line_in),
      .cfg          (cfg_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.clock_line        = rsp_data_ff.clock_line;
   assign rsp_ch.data_line_out     = rsp_data_ff.data_line_out;
   assign rsp_ch.data_drive_enable = rsp_data_ff.data_drive_enable;
   assign rsp_ch.busy_res          = rsp_data_ff.busy_res;
   assign rsp_ch.done_res          = rsp_data_ff.done_res;
   assign rsp_ch.read_byte         = rsp_data_ff.read_byte;

endmodule

>>> src/twsrm_engine.sv
// ----------------------------------------------------------------------------
// Two-wire sensor register master engine
// Phase sequencer, tick counter and shift registers; advances one tick per
// accepted request and presents the pin levels of that tick.
// ----------------------------------------------------------------------------
module twsrm_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [1:0]             action,
   input  logic [6:0]             reg_address,
   input  logic [7:0]             write_byte,
   input  logic                   data_line_in,
   input  twsrm_pkg::cfg_type     cfg,
   output twsrm_pkg::result_type  result
);

   twsrm_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  operation_ff, operation_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [15:0] shift_out_ff, shift_out_in;
   logic [7:0]  shift_in_ff, shift_in_in;
   logic        clock_level_ff, clock_level_in;
   logic        data_level_ff, data_level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= twsrm_pkg::PH_IDLE;
         operation_ff   <= twsrm_pkg::ACT_TICK;
         bit_count_ff   <= '0;
         tick_count_ff  <= '0;
         shift_out_ff   <= '0;
         shift_in_ff    <= '0;
         clock_level_ff <= 1'b1;
         data_level_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         operation_ff   <= operation_in;
         bit_count_ff   <= bit_count_in;
         tick_count_ff  <= tick_count_in;
         shift_out_ff   <= shift_out_in;
         shift_in_ff    <= shift_in_in;
         clock_level_ff <= clock_level_in;
         data_level_ff  <= data_level_in;
      end
   end

   always_comb begin
      twsrm_pkg::phase_type cur;
      logic        receiving;
      logic        drive;
      logic        busy;
      logic        done;
      logic [15:0] len;
      logic [16:0] tick_next;

      phase_in       = phase_ff;
      operation_in   = operation_ff;
      bit_count_in   = bit_count_ff;
      tick_count_in  = tick_count_ff;
      shift_out_in   = shift_out_ff;
      shift_in_in    = shift_in_ff;
      clock_level_in = clock_level_ff;
      data_level_in  = data_level_ff;
      drive          = 1'b1;
      busy           = 1'b0;
      done           = 1'b0;
      len            = 16'd1;
      tick_next      = '0;

      // A start command is taken only while idle; its tick is the first one.
      if (phase_ff == twsrm_pkg::PH_IDLE && action != twsrm_pkg::ACT_TICK) begin
         operation_in  = action;
         bit_count_in  = '0;
         tick_count_in = '0;
         unique case (action)
            twsrm_pkg::ACT_WRITE: begin
               shift_out_in = {1'b1, reg_address, write_byte};
               phase_in     = twsrm_pkg::PH_LOW;
            end
            twsrm_pkg::ACT_READ: begin
               shift_out_in = {1'b0, reg_address, 8'h00};
               phase_in     = twsrm_pkg::PH_LOW;
            end
            default: begin
               phase_in = twsrm_pkg::PH_RS_PRE;
            end
         endcase
      end

      receiving = (operation_in == twsrm_pkg::ACT_READ) &&
                  (bit_count_in[4] || bit_count_in[3]);
      cur = phase_in;

      if (cur != twsrm_pkg::PH_IDLE) begin
         busy = 1'b1;
         unique case (cur)
            twsrm_pkg::PH_LOW: begin
               clock_level_in = 1'b0;
               drive          = !receiving;
               len            = cfg.phase_ticks;
            end
            twsrm_pkg::PH_HIGH: begin
               clock_level_in = 1'b1;
               drive          = !receiving;
               // Driven data changes on the rising edge, the first high tick.
               if (!receiving && tick_count_in == 16'd0) begin
                  data_level_in = shift_out_in[15];
               end
               len = cfg.phase_ticks;
            end
            twsrm_pkg::PH_TURN: begin
               clock_level_in = 1'b1;
               drive          = 1'b0;
               len            = cfg.turnaround_ticks;
            end
            twsrm_pkg::PH_RS_LOW: begin
               clock_level_in = 1'b0;
               len            = cfg.phase_ticks;
            end
            default: begin
               clock_level_in = 1'b1;
               len            = cfg.resync_hold_ticks;
            end
         endcase
         if (len == 16'd0) begin
            len = 16'd1;
         end

         // The 17-bit count also covers the wrap of a full 16-bit count.
         tick_next = {1'b0, tick_count_in} + 17'd1;
         if (tick_next >= {1'b0, len}) begin
            tick_count_in = '0;
            unique case (cur)
               twsrm_pkg::PH_LOW: begin
                  phase_in = twsrm_pkg::PH_HIGH;
               end
               twsrm_pkg::PH_HIGH: begin
                  shift_out_in = {shift_out_in[14:0], receiving & data_line_in};
                  bit_count_in = bit_count_in + 5'd1;
                  if (bit_count_in[4]) begin
                     if (operation_in == twsrm_pkg::ACT_READ) begin
                        shift_in_in = shift_out_in[7:0];
                     end
                     phase_in = twsrm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else if (operation_in == twsrm_pkg::ACT_READ &&
                               bit_count_in == 5'd8 &&
                               cfg.turnaround_ticks != 16'd0) begin
                     phase_in = twsrm_pkg::PH_TURN;
                  end else begin
                     phase_in = twsrm_pkg::PH_LOW;
                  end
               end
               twsrm_pkg::PH_TURN: begin
                  phase_in = twsrm_pkg::PH_LOW;
               end
               twsrm_pkg::PH_RS_PRE: begin
                  phase_in = twsrm_pkg::PH_RS_LOW;
               end
               twsrm_pkg::PH_RS_LOW: begin
                  phase_in = twsrm_pkg::PH_RS_POST;
               end
               default: begin
                  phase_in = twsrm_pkg::PH_IDLE;
                  done     = 1'b1;
               end
            endcase
         end else begin
            tick_count_in = tick_next[15:0];
         end
      end else begin
         clock_level_in = 1'b1;
      end

      result.clock_line        = clock_level_in;
      result.data_line_out     = data_level_in;
      result.data_drive_enable = drive;
      result.busy_res          = busy;
      result.done_res          = done;
      result.read_byte         = shift_in_in;
   end

endmodule

>>> src/twsrm_checker.sv
// ----------------------------------------------------------------------------
// Two-wire sensor register master checker
// Port-level assertions on the serial master, attached to the top level.
// ----------------------------------------------------------------------------
module twsrm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       clock_line,
   input logic       data_drive_enable,
   input logic       busy_res,
   input logic       done_res,
   input logic [7:0] read_byte
);

   // A finished operation is still busy on its final tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> busy_res)
      else $error("done response without busy");

   // An idle link keeps its clock high and drives the data line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy_res |-> clock_line && data_drive_enable)
      else $error("idle response with clock low or data released");

   // An empty response register never holds back a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // A response follows every accepted request in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   // A stalled response keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) &&
      $stable(busy_res) && $stable(done_res))
      else $error("stalled response changed");

endmodule

bind two_wire_sensor_register_master_top twsrm_checker u_twsrm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .clock_line        (rsp_ch.clock_line),
   .data_drive_enable (rsp_ch.data_drive_enable),
   .busy_res          (rsp_ch.busy_res),
   .done_res          (rsp_ch.done_res),
   .read_byte         (rsp_ch.read_byte)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Two-wire sensor register master testbench
// Drives tick requests through the valid/ready channels and compares every
// response with a cycle model of the pin sequencer: write, read and resync
// sequences, ignored starts, zero and long phase lengths, and response
// back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned ROUND_TICKS = 55;

   typedef enum {DIN_LOW, DIN_HIGH, DIN_RANDOM} din_pattern_type;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] reg_address;
      logic [7:0] write_byte;
      logic       data_line_in;
   } tick_request_type;

   logic clock;
   logic reset;
   logic                                  csr_write_enable;
   logic [twsrm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [twsrm_pkg::CSR_WIDTH-1:0]       csr_write_data;

   twsrm_req_if req_ch ();
   twsrm_rsp_if rsp_ch ();

   two_wire_sensor_register_master_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Link model state.
   twsrm_pkg::cfg_type   link_cfg;
   twsrm_pkg::phase_type link_phase;
   logic [1:0]  link_op;
   logic [4:0]  bits_done;
   logic [15:0] ticks_in_phase;
   logic [15:0] shift_reg;
   logic [7:0]  captured_byte;
   logic        clock_level;
   logic        data_level;

   twsrm_pkg::result_type expected_pins[$];

   int unsigned error_count = 0;
   int unsigned ticks_sent = 0;
   int unsigned started_ops[4] = '{0, 0, 0, 0};
   int unsigned ignored_starts = 0;
   int unsigned burst_left = 0;
   int unsigned hold_off_requests = 0;
   int unsigned idle_cycles = 0;
   bit          steady_flow = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   // Advances the link model by one tick and returns the pin levels of it.
   function automatic twsrm_pkg::result_type advance_link(input tick_request_type r);
      twsrm_pkg::result_type res;
      logic        drive;
      logic        busy;
      logic        done;
      logic        receiving;
      logic [15:0] len;
      drive = 1'b1;
      busy = 1'b0;
      done = 1'b0;
      len = 16'd1;
      if (r.action != twsrm_pkg::ACT_TICK) begin
         if (link_phase == twsrm_pkg::PH_IDLE) begin
            started_ops[r.action]++;
         end else begin
            ignored_starts++;
         end
      end
      if (link_phase == twsrm_pkg::PH_IDLE && r.action != twsrm_pkg::ACT_TICK) begin
         link_op = r.action;
         bits_done = '0;
         ticks_in_phase = '0;
         if (r.action == twsrm_pkg::ACT_WRITE) begin
            shift_reg = {1'b1, r.reg_address, r.write_byte};
            link_phase = twsrm_pkg::PH_LOW;
         end else if (r.action == twsrm_pkg::ACT_READ) begin
            shift_reg = {1'b0, r.reg_address, 8'h00};
            link_phase = twsrm_pkg::PH_LOW;
         end else begin
            link_phase = twsrm_pkg::PH_RS_PRE;
         end
      end
      receiving = (link_op == twsrm_pkg::ACT_READ) && (bits_done >= 5'd8);
      if (link_phase != twsrm_pkg::PH_IDLE) begin
         busy = 1'b1;
         case (link_phase)
            twsrm_pkg::PH_LOW: begin
               clock_level = 1'b0;
               drive = !receiving;
               len = at_least_one(link_cfg.phase_ticks);
            end
            twsrm_pkg::PH_HIGH: begin
               clock_level = 1'b1;
               drive = !receiving;
               // Driven data changes on the rising edge of the clock line.
               if (!receiving && ticks_in_phase == 16'd0) data_level = shift_reg[15];
               len = at_least_one(link_cfg.phase_ticks);
            end
            twsrm_pkg::PH_TURN: begin
               clock_level = 1'b1;
               drive = 1'b0;
               len = at_least_one(link_cfg.turnaround_ticks);
            end
            twsrm_pkg::PH_RS_LOW: begin
               clock_level = 1'b0;
               len = at_least_one(link_cfg.phase_ticks);
            end
            default: begin
               clock_level = 1'b1;
               len = at_least_one(link_cfg.resync_hold_ticks);
            end
         endcase
         ticks_in_phase = ticks_in_phase + 16'd1;
         if (ticks_in_phase >= len || ticks_in_phase == 16'd0) begin
            ticks_in_phase = '0;
            case (link_phase)
               twsrm_pkg::PH_LOW: link_phase = twsrm_pkg::PH_HIGH;
               twsrm_pkg::PH_HIGH: begin
                  shift_reg = {shift_reg[14:0], receiving & r.data_line_in};
                  bits_done = bits_done + 5'd1;
                  if (bits_done >= 5'd16) begin
                     if (link_op == twsrm_pkg::ACT_READ) captured_byte = shift_reg[7:0];
                     link_phase = twsrm_pkg::PH_IDLE;
                     done = 1'b1;
                  end else if (link_op == twsrm_pkg::ACT_READ && bits_done == 5'd8 &&
                               link_cfg.turnaround_ticks != 16'd0) begin
                     link_phase = twsrm_pkg::PH_TURN;
                  end else begin
                     link_phase = twsrm_pkg::PH_LOW;
                  end
               end
               twsrm_pkg::PH_TURN: link_phase = twsrm_pkg::PH_LOW;
               twsrm_pkg::PH_RS_PRE: link_phase = twsrm_pkg::PH_RS_LOW;
               twsrm_pkg::PH_RS_LOW: link_phase = twsrm_pkg::PH_RS_POST;
               default: begin
                  link_phase = twsrm_pkg::PH_IDLE;
                  done = 1'b1;
               end
            endcase
         end
      end else begin
         clock_level = 1'b1;
      end
      res.clock_line = clock_level;
      res.data_line_out = data_level;
      res.data_drive_enable = drive;
      res.busy_res = busy;
      res.done_res = done;
      res.read_byte = captured_byte;
      return res;
   endfunction

   function automatic tick_request_type make_request(input logic [1:0] action,
                                                     input logic [6:0] addr,
                                                     input logic [7:0] wbyte,
                                                     input logic din);
      tick_request_type r;
      r.action = action;
      r.reg_address = addr;
      r.write_byte = wbyte;
      r.data_line_in = din;
      return r;
   endfunction

   // Called and returns at a falling edge. Bursts of requests are separated
   // by random gaps unless steady flow is asked for.
   task automatic send_tick(input tick_request_type r);
      int unsigned gap;
      if (!steady_flow) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= r.action;
      req_ch.reg_address <= r.reg_address;
      req_ch.write_byte <= r.write_byte;
      req_ch.data_line_in <= r.data_line_in;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      expected_pins.push_back(advance_link(r));
      ticks_sent++;
      @(negedge clock);
   endtask

   // Starts one operation and ticks until the link is idle again. With
   // meddle set, further start requests are mixed in and must be ignored.
   task automatic run_operation(input logic [1:0] action, input logic [6:0] addr,
                                input logic [7:0] wbyte, input din_pattern_type din_mode,
                                input bit meddle);
      tick_request_type r;
      logic             din;
      send_tick(make_request(action, addr, wbyte, 1'($urandom_range(0, 1))));
      while (link_phase != twsrm_pkg::PH_IDLE) begin
         case (din_mode)
            DIN_LOW: din = 1'b0;
            DIN_HIGH: din = 1'b1;
            default: din = 1'($urandom_range(0, 1));
         endcase
         r = make_request(twsrm_pkg::ACT_TICK, 7'($urandom), 8'($urandom), din);
         if (meddle && $urandom_range(0, 7) == 0) r.action = 2'($urandom_range(1, 3));
         send_tick(r);
      end
   endtask

   // Brings the link to idle and waits until every response has been taken.
   task automatic settle_link();
      while (link_phase != twsrm_pkg::PH_IDLE) begin
         send_tick(make_request(twsrm_pkg::ACT_TICK, 7'($urandom), 8'($urandom),
                                1'($urandom_range(0, 1))));
      end
      req_ch.valid <= 1'b0;
      while (expected_pins.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] phase_len, input logic [15:0] turn_len,
                                 input logic [15:0] hold_len);
      settle_link();
      csr_write_enable <= 1'b1;
      csr_index <= twsrm_pkg::CSR_PHASE_TICKS;
      csr_write_data <= phase_len;
      @(negedge clock);
      csr_index <= twsrm_pkg::CSR_TURNAROUND_TICKS;
      csr_write_data <= turn_len;
      @(negedge clock);
      csr_index <= twsrm_pkg::CSR_RESYNC_HOLD_TICKS;
      csr_write_data <= hold_len;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      link_cfg.phase_ticks = phase_len;
      link_cfg.turnaround_ticks = turn_len;
      link_cfg.resync_hold_ticks = hold_len;
   endtask

   task automatic test_idle_levels();
      repeat (4) send_tick(make_request(twsrm_pkg::ACT_TICK, 7'h7F, 8'hFF, 1'b1));
      repeat (4) send_tick(make_request(twsrm_pkg::ACT_TICK, 7'h00, 8'h00, 1'b0));
   endtask

   task automatic test_reset_timing();
      run_operation(twsrm_pkg::ACT_WRITE, 7'h7F, 8'hFF, DIN_RANDOM, 1'b1);
      run_operation(twsrm_pkg::ACT_READ, 7'h00, 8'h00, DIN_HIGH, 1'b1);
      run_operation(twsrm_pkg::ACT_RESYNC, 7'h55, 8'hAA, DIN_RANDOM, 1'b1);
   endtask

   task automatic test_field_extremes();
      apply_settings(16'd1, 16'd0, 16'd1);
      run_operation(twsrm_pkg::ACT_WRITE, 7'h00, 8'h00, DIN_LOW, 1'b0);
      run_operation(twsrm_pkg::ACT_WRITE, 7'h7F, 8'hFF, DIN_HIGH, 1'b0);
      run_operation(twsrm_pkg::ACT_READ, 7'h7F, 8'hFF, DIN_HIGH, 1'b0);
      run_operation(twsrm_pkg::ACT_READ, 7'h00, 8'h00, DIN_LOW, 1'b0);
      run_operation(twsrm_pkg::ACT_READ, 7'h2A, 8'h55, DIN_RANDOM, 1'b1);
      run_operation(twsrm_pkg::ACT_RESYNC, 7'h7F, 8'hFF, DIN_RANDOM, 1'b1);
   endtask

   // A zero phase or hold length behaves as one tick.
   task automatic test_zero_lengths();
      apply_settings(16'd0, 16'd0, 16'd0);
      run_operation(twsrm_pkg::ACT_WRITE, 7'h35, 8'hC3, DIN_RANDOM, 1'b1);
      run_operation(twsrm_pkg::ACT_READ, 7'h4C, 8'h3C, DIN_RANDOM, 1'b0);
      run_operation(twsrm_pkg::ACT_RESYNC, 7'h01, 8'h80, DIN_RANDOM, 1'b0);
   endtask

   // The receiver holds off while requests keep coming, so the block fills.
   task automatic test_response_backpressure();
      apply_settings(16'd1, 16'd3, 16'd2);
      steady_flow = 1;
      hold_off_requests++;
      run_operation(twsrm_pkg::ACT_WRITE, 7'($urandom), 8'($urandom), DIN_RANDOM, 1'b1);
      run_operation(twsrm_pkg::ACT_READ, 7'($urandom), 8'($urandom), DIN_RANDOM, 1'b0);
      steady_flow = 0;
   endtask

   // Long lengths on each register, one at a time; only the turnaround length goes past eight bits.
   task automatic test_longest_lengths();
      steady_flow = 1;
      apply_settings(16'd1, 16'd256, 16'd1);
      run_operation(twsrm_pkg::ACT_READ, 7'h5A, 8'h00, DIN_RANDOM, 1'b0);
      apply_settings(16'd40, 16'd1, 16'd1);
      run_operation(twsrm_pkg::ACT_RESYNC, 7'h00, 8'h00, DIN_RANDOM, 1'b0);
      apply_settings(16'd1, 16'd0, 16'd64);
      run_operation(twsrm_pkg::ACT_RESYNC, 7'h00, 8'h00, DIN_RANDOM, 1'b0);
      steady_flow = 0;
   endtask

   // Mostly complete operations with random content; starts while busy and
   // bare ticks while idle are mixed in as noise.
   task automatic test_random_traffic();
      tick_request_type r;
      int unsigned      pick;
      for (int round = 0; round < 4; round++) begin
         if (round == 0) begin
            apply_settings(twsrm_pkg::PHASE_TICKS_RESET, twsrm_pkg::TURNAROUND_TICKS_RESET,
                           twsrm_pkg::RESYNC_HOLD_TICKS_RESET);
         end else begin
            apply_settings(($urandom_range(0, 3) == 0) ? 16'($urandom_range(2, 3)) : 16'd1,
                           16'($urandom_range(0, 4)), 16'($urandom_range(1, 6)));
         end
         for (int n = 0; n < ROUND_TICKS; n++) begin
            r = make_request(twsrm_pkg::ACT_TICK, 7'($urandom), 8'($urandom),
                             1'($urandom_range(0, 1)));
            if (link_phase == twsrm_pkg::PH_IDLE) begin
               pick = $urandom_range(0, 9);
               if (pick == 1) r.action = twsrm_pkg::ACT_RESYNC;
               else if (pick >= 2 && pick <= 5) r.action = twsrm_pkg::ACT_WRITE;
               else if (pick >= 6) r.action = twsrm_pkg::ACT_READ;
            end else if ($urandom_range(0, 19) == 0) begin
               r.action = 2'($urandom_range(1, 3));
            end
            send_tick(r);
         end
      end
   endtask

   task automatic compare_pin(input string label, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 30) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : check_responses
      twsrm_pkg::result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_pins.size() == 0) begin
            error_count++;
            if (error_count <= 30) $display("%0t: response with no request outstanding", $time);
         end else begin
            want = expected_pins.pop_front();
            compare_pin("clock_line", 8'(want.clock_line), 8'(rsp_ch.clock_line));
            compare_pin("data_line_out", 8'(want.data_line_out), 8'(rsp_ch.data_line_out));
            compare_pin("data_drive_enable", 8'(want.data_drive_enable),
                        8'(rsp_ch.data_drive_enable));
            compare_pin("busy_res", 8'(want.busy_res), 8'(rsp_ch.busy_res));
            compare_pin("done_res", 8'(want.done_res), 8'(rsp_ch.done_res));
            compare_pin("read_byte", want.read_byte, rsp_ch.read_byte);
         end
      end
   end

   // Receiver: runs of ready broken by stalls, plus the requested hold-offs.
   initial begin : drain_responses
      int unsigned hold_left;
      int unsigned run_left;
      int unsigned stall_left;
      int unsigned hold_offs_served;
      hold_left = 0;
      run_left = 0;
      stall_left = 0;
      hold_offs_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_offs_served < hold_off_requests) begin
            hold_offs_served++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (steady_flow) begin
            rsp_ch.ready <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            run_left = $urandom_range(0, 15);
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) :
                                                       $urandom_range(0, 3);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or response accepted for %0d cycles", $time,
                  WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = twsrm_pkg::ACT_TICK;
      req_ch.reg_address = '0;
      req_ch.write_byte = '0;
      req_ch.data_line_in = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = twsrm_pkg::CSR_PHASE_TICKS;
      csr_write_data = '0;
      link_cfg.phase_ticks = twsrm_pkg::PHASE_TICKS_RESET;
      link_cfg.turnaround_ticks = twsrm_pkg::TURNAROUND_TICKS_RESET;
      link_cfg.resync_hold_ticks = twsrm_pkg::RESYNC_HOLD_TICKS_RESET;
      link_phase = twsrm_pkg::PH_IDLE;
      link_op = twsrm_pkg::ACT_TICK;
      bits_done = '0;
      ticks_in_phase = '0;
      shift_reg = '0;
      captured_byte = '0;
      clock_level = 1'b1;
      data_level = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_levels();
      test_reset_timing();
      test_field_extremes();
      test_zero_lengths();
      test_response_backpressure();
      test_longest_lengths();
      test_random_traffic();
      settle_link();

      $display("Sent %0d ticks: %0d writes, %0d reads, %0d resyncs started, %0d starts ignored.",
               ticks_sent, started_ops[twsrm_pkg::ACT_WRITE], started_ops[twsrm_pkg::ACT_READ],
               started_ops[twsrm_pkg::ACT_RESYNC], ignored_starts);
      $display("Lengths ranged from zero to 256 ticks; %0d mismatches found.", error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
